FILE: src/stdp_pkg.sv
// Shared constants, types and exponential tables for the STDP weight update block.
// Used by stdp_div, stdp_pair_weight_update and the testbench files; no other dependencies.
package stdp_pkg;

    localparam int TIME_W     = 32;
    localparam int EXP_DEPTH  = 256;
    localparam int EXP_IDX_W  = $clog2(EXP_DEPTH);
    localparam int INT_STEPS  = 32;
    localparam int INT_IDX_W  = $clog2(INT_STEPS);
    localparam int TAU_W      = 20;
    localparam int AMP_W      = 16;
    localparam int TRACE_W    = 32;
    localparam int WEIGHT_W   = 32;
    localparam int FAC_W      = 31;     // Q1.30 decay factor, never above 1.0
    localparam int QUO_W      = TIME_W + EXP_IDX_W;
    localparam int QUO_CNT_W  = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_POT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_DEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_POT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_DEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd4;

    typedef logic [FAC_W-1:0] t_frac_tab [EXP_DEPTH];
    typedef logic [FAC_W-1:0] t_int_tab  [INT_STEPS];

    typedef struct packed {
        logic               start;
        logic [QUO_W-1:0]   dividend;
        logic [TAU_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quot;
    } t_div_rsp;

    // exp(-arg) in Q2.30 by a series up to the 20th power; elaboration time only
    function automatic logic [63:0] exp_series(logic [63:0] arg);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = 64'd0;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * arg) >> 30) / 64'(n);
            if (n % 2 == 1) neg = neg + term;
            else            pos = pos + term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic t_frac_tab build_frac_tab();
        t_frac_tab tab;
        for (int i = 0; i < EXP_DEPTH; i++)
            tab[i] = FAC_W'(exp_series((64'(i) << 30) / EXP_DEPTH));
        return tab;
    endfunction

    function automatic t_int_tab build_int_tab();
        t_int_tab    tab;
        logic [63:0] e1;
        e1 = exp_series(64'd1 << 30);
        tab[0] = FAC_W'(64'd1 << 30);
        for (int i = 1; i < INT_STEPS; i++)
            tab[i] = FAC_W'((64'(tab[i-1]) * e1 + (64'd1 << 29)) >> 30);
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();
    localparam t_int_tab  INT_TAB  = build_int_tab();

endpackage

FILE: src/stdp_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on stdp_pkg for widths and the request/response structs.
module stdp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stdp_pkg::t_div_req i_req,
    output stdp_pkg::t_div_rsp o_rsp
);
    import stdp_pkg::*;

    logic [TAU_W-1:0]     r_rem, n_rem;
    logic [QUO_W-1:0]     r_quo, n_quo;
    logic [TAU_W-1:0]     r_div;
    logic [QUO_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [TAU_W:0]       trial;
    logic                 fits;

    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_comb begin
        n_rem = fits ? TAU_W'(trial - {1'b0, r_div}) : trial[TAU_W-1:0];
        n_quo = {r_quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QUO_CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

FILE: src/stdp_pair_weight_update.sv
// Top level of the all-to-all pair STDP weight update block.
// Depends on stdp_pkg and instantiates stdp_div.
//
// Usage:
//  - Slave stream (i_s_*): one spike event per transfer. tdata is the 32-bit
//    timestamp; tuser carries the pre, post and restart flags.
//  - Master stream (o_m_*): one result per event from an output register: the
//    running weight sum in tdata, the order-error and saturation flags in tuser.
//  - Config channel (i_cfg_*): register writes, always ready; write only
//    while no event is in flight.
//  - Sequencing: one shared divider and one shared 32x32 multiplier under a
//    sequencer. Each trace takes a pass: the 40-step division of {dt, 8'b0}
//    by tau, then the factor multiply and round, trace multiply and write steps.
//    After the spike, weight and result steps a normal event reaches the output
//    register; an out-of-order event goes from idle straight to the result step.
//  - Events: one at a time; a new one is taken only when the sequencer is idle.
//  - Reset clears traces, last time and weight sum, loads register defaults.
//    The exponential tables are constants, so no warm-up is needed.
//  - A stalled receiver keeps the result in the output register; the next
//    event is still taken and waits at its last step until that result transfers.
module stdp_pair_weight_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [stdp_pkg::TIME_W-1:0]      i_s_tdata,   // [31:0] spike_time
    input  logic [2:0]                       i_s_tuser,   // [0] pre_fired [1] post_fired
                                                          // [2] restart
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [stdp_pkg::WEIGHT_W-1:0]    o_m_tdata,   // [31:0] weight_change
    output logic [1:0]                       o_m_tuser,   // [0] order_error [1] saturated
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stdp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import stdp_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV_GO   = 4'd1;
    localparam logic [3:0] ST_DIV_WAIT = 4'd2;
    localparam logic [3:0] ST_FAC_MUL  = 4'd3;
    localparam logic [3:0] ST_FAC_RND  = 4'd4;
    localparam logic [3:0] ST_DEC_MUL  = 4'd5;
    localparam logic [3:0] ST_DEC_WR   = 4'd6;
    localparam logic [3:0] ST_SPIKE    = 4'd7;
    localparam logic [3:0] ST_DEP_MUL  = 4'd8;
    localparam logic [3:0] ST_DEP_ADD  = 4'd9;
    localparam logic [3:0] ST_POT_MUL  = 4'd10;
    localparam logic [3:0] ST_POT_ADD  = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    // config registers
    logic [AMP_W-1:0]    r_amp_pot, r_amp_dep;
    logic [TAU_W-1:0]    r_tau_pot, r_tau_dep;
    logic [TIME_W-1:0]   r_start;

    // state
    logic [TRACE_W-1:0]  r_pre_tr, r_post_tr;
    logic [TIME_W-1:0]   r_prev;
    logic [WEIGHT_W-1:0] r_weight;

    // sequencer
    logic [3:0]          r_st, n_st;
    logic                r_sel;         // 0: pre trace / tau_pot, 1: post trace / tau_dep
    logic [TIME_W-1:0]   r_dt;
    logic [TIME_W-1:0]   r_time;
    logic                r_pre, r_post;
    logic                r_sat;
    logic                r_late;
    logic [63:0]         r_prod;
    logic [FAC_W-1:0]    r_fac;
    logic                r_out_valid;
    logic [WEIGHT_W-1:0] r_out_data;
    logic                r_out_err;
    logic                r_out_sat;

    logic                s_xfer;
    logic                m_xfer;
    logic                out_free;
    logic                out_load;
    logic [TIME_W-1:0]   prev_eff;
    logic                late;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic [TAU_W-1:0]    tau_sel;

    logic [31:0]         mul_a, mul_b;
    logic                q_big;
    logic [63:0]         rnd30;
    logic [TRACE_W-1:0]  dec_val;
    logic [TRACE_W:0]    pre_add, post_add;
    logic [40:0]         wdelta;
    logic [41:0]         wsum;
    logic [WEIGHT_W-1:0] wclip;
    logic                wovf;
    logic                active;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_st == ST_IDLE);
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign m_xfer      = r_out_valid && i_m_tready;
    // output register can take a new result this cycle
    assign out_free    = !r_out_valid || i_m_tready;
    assign out_load    = (r_st == ST_DONE) && out_free;

    // restart clears the last time before the order check
    assign prev_eff = i_s_tuser[2] ? '0 : r_prev;
    assign late     = i_s_tdata < prev_eff;

    // ---------------- shared divider ----------------
    assign tau_sel = r_sel ? r_tau_dep : r_tau_pot;
    always_comb begin
        div_req.start    = (r_st == ST_DIV_GO);
        div_req.dividend = {r_dt, EXP_IDX_W'(0)};
        div_req.divisor  = (tau_sel == '0) ? TAU_W'(1) : tau_sel;
    end

    stdp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // quotient of dt*256/tau: upper bits are whole tau steps, lower the fraction
    assign q_big = |div_rsp.quot[QUO_W-1:EXP_IDX_W+INT_IDX_W];

    // ---------------- shared multiplier ----------------
    always_comb begin
        case (r_st)
            ST_FAC_MUL: begin
                mul_a = 32'(INT_TAB[div_rsp.quot[EXP_IDX_W+INT_IDX_W-1:EXP_IDX_W]]);
                mul_b = 32'(FRAC_TAB[div_rsp.quot[EXP_IDX_W-1:0]]);
            end
            ST_DEC_MUL: begin
                mul_a = r_sel ? r_post_tr : r_pre_tr;
                mul_b = 32'(r_fac);
            end
            ST_DEP_MUL: begin
                mul_a = 32'(r_amp_dep);
                mul_b = r_post_tr;
            end
            default: begin
                mul_a = 32'(r_amp_pot);
                mul_b = r_pre_tr;
            end
        endcase
    end

    assign rnd30    = r_prod + (64'd1 << 29);
    assign dec_val  = rnd30[TRACE_W+29:30];
    assign pre_add  = {1'b0, r_pre_tr}  + (TRACE_W+1)'(32'h10000);
    assign post_add = {1'b0, r_post_tr} + (TRACE_W+1)'(32'h10000);
    assign active   = r_time >= r_start;

    // weight step, rounded Q7.24, then saturating add or subtract
    always_comb begin
        logic [63:0] rnd8;
        rnd8   = r_prod + 64'd128;
        wdelta = rnd8[48:8];
        if (r_st == ST_DEP_ADD)
            wsum = {{10{r_weight[WEIGHT_W-1]}}, r_weight} - {1'b0, wdelta};
        else
            wsum = {{10{r_weight[WEIGHT_W-1]}}, r_weight} + {1'b0, wdelta};
        wovf = 1'b0;
        if (!wsum[41] && (|wsum[40:31])) begin
            wclip = 32'h7FFF_FFFF;
            wovf  = 1'b1;
        end else if (wsum[41] && !(&wsum[40:31])) begin
            wclip = 32'h8000_0000;
            wovf  = 1'b1;
        end else begin
            wclip = wsum[31:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:     if (s_xfer) n_st = late ? ST_DONE : ST_DIV_GO;
            ST_DIV_GO:   n_st = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_rsp.done) n_st = ST_FAC_MUL;
            ST_FAC_MUL:  n_st = ST_FAC_RND;
            ST_FAC_RND:  n_st = ST_DEC_MUL;
            ST_DEC_MUL:  n_st = ST_DEC_WR;
            ST_DEC_WR:   n_st = r_sel ? ST_SPIKE : ST_DIV_GO;
            ST_SPIKE: begin
                if (active && r_pre)       n_st = ST_DEP_MUL;
                else if (active && r_post) n_st = ST_POT_MUL;
                else                       n_st = ST_DONE;
            end
            ST_DEP_MUL:  n_st = ST_DEP_ADD;
            ST_DEP_ADD:  n_st = r_post ? ST_POT_MUL : ST_DONE;
            ST_POT_MUL:  n_st = ST_POT_ADD;
            ST_POT_ADD:  n_st = ST_DONE;
            ST_DONE:     if (out_free) n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pre_tr    <= '0;
            r_post_tr   <= '0;
            r_prev      <= '0;
            r_weight    <= '0;
            r_amp_pot   <= AMP_W'(328);
            r_amp_dep   <= AMP_W'(344);
            r_tau_pot   <= TAU_W'(20000);
            r_tau_dep   <= TAU_W'(20000);
            r_start     <= '0;
        end else begin
            r_st <= n_st;
            if (out_load)    r_out_valid <= 1'b1;
            else if (m_xfer) r_out_valid <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_AMP_POT: r_amp_pot <= i_cfg_data[AMP_W-1:0];
                    CFG_AMP_DEP: r_amp_dep <= i_cfg_data[AMP_W-1:0];
                    CFG_TAU_POT: r_tau_pot <= i_cfg_data[TAU_W-1:0];
                    CFG_TAU_DEP: r_tau_dep <= i_cfg_data[TAU_W-1:0];
                    CFG_START:   r_start   <= i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end

            case (r_st)
                ST_IDLE: begin
                    if (s_xfer) begin
                        r_sel <= 1'b0;
                        if (i_s_tuser[2]) begin
                            r_pre_tr  <= '0;
                            r_post_tr <= '0;
                            r_weight  <= '0;
                        end
                        // ignored event keeps the last time and reports the unchanged sum
                        if (!late) r_prev <= i_s_tdata;
                    end
                end
                ST_DEC_WR: begin
                    if (r_sel) r_post_tr <= dec_val;
                    else       r_pre_tr  <= dec_val;
                    r_sel <= 1'b1;
                end
                ST_SPIKE: begin
                    if (r_pre)  r_pre_tr  <= pre_add[TRACE_W]  ? '1 : pre_add[TRACE_W-1:0];
                    if (r_post) r_post_tr <= post_add[TRACE_W] ? '1 : post_add[TRACE_W-1:0];
                end
                ST_DEP_ADD, ST_POT_ADD: r_weight <= wclip;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_st)
            ST_IDLE: begin
                if (s_xfer) begin
                    r_dt   <= i_s_tdata - prev_eff;
                    r_time <= i_s_tdata;
                    r_pre  <= i_s_tuser[0];
                    r_post <= i_s_tuser[1];
                    r_sat  <= 1'b0;
                    r_late <= late;
                end
            end
            ST_FAC_RND: r_fac <= q_big ? '0 : rnd30[FAC_W+29:30];
            ST_SPIKE: begin
                if ((r_pre && pre_add[TRACE_W]) || (r_post && post_add[TRACE_W]))
                    r_sat <= 1'b1;
            end
            ST_DEP_ADD, ST_POT_ADD: if (wovf) r_sat <= 1'b1;
            ST_DONE: begin
                if (out_load) begin
                    r_out_data <= r_weight;
                    r_out_err  <= r_late;
                    r_out_sat  <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = {r_out_sat, r_out_err};

endmodule

FILE: tb/stdp_checker.sv
// Scoreboard for stdp_pair_weight_update: watches the config, event and result channels,
// predicts each result from its own copy of the state, and counts mismatches.
// Depends on stdp_pkg for register indexes and widths.
`timescale 1ns / 1ps

module stdp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [stdp_pkg::TIME_W-1:0]    i_s_tdata,    // [31:0] spike_time
    input  logic [2:0]                     i_s_tuser,    // [0] pre [1] post [2] restart
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [stdp_pkg::WEIGHT_W-1:0]  i_m_tdata,    // [31:0] weight_change
    input  logic [1:0]                     i_m_tuser,    // [0] order_error [1] saturated
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [stdp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import stdp_pkg::*;

    typedef struct {
        logic [31:0] weight;
        logic        order_err;
        logic        sat;
    } t_weight_result;

    t_weight_result weight_q[$];

    logic [63:0] frac_lut [EXP_DEPTH];
    logic [63:0] whole_lut[INT_STEPS];

    // model copy of registers and state
    logic [15:0]        amp_pot, amp_dep;
    logic [19:0]        tau_pot, tau_dep;
    logic [31:0]        start_at;
    logic [63:0]        pre_tr, post_tr;
    logic [31:0]        last_t;
    logic signed [31:0] wsum;

    // exp(-arg), arg in Q2.30, series up to the 20th power with odd terms summed apart
    function automatic logic [63:0] neg_exp(logic [63:0] arg);
        logic [63:0] term, pos, neg;
        term = 64'd1 << 30;
        pos  = term;
        neg  = 0;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * arg) >> 30) / n;
            if (n & 1) neg += term;
            else       pos += term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    initial begin
        logic [63:0] e1;
        for (int i = 0; i < EXP_DEPTH; i++)
            frac_lut[i] = neg_exp((64'(i) << 30) / EXP_DEPTH);
        e1 = neg_exp(64'd1 << 30);
        whole_lut[0] = 64'd1 << 30;
        for (int i = 1; i < INT_STEPS; i++)
            whole_lut[i] = (whole_lut[i-1] * e1 + (64'd1 << 29)) >> 30;
    end

    function automatic logic [63:0] decay_gain(logic [63:0] dt, logic [19:0] tau);
        logic [63:0] tq, q, r, idx;
        tq = (tau == 0) ? 64'd1 : 64'(tau);
        q  = dt / tq;
        r  = dt % tq;
        if (q >= INT_STEPS) return 0;
        idx = (r * EXP_DEPTH) / tq;
        if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
        return (whole_lut[q] * frac_lut[idx] + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] add_spike(logic [63:0] tr, inout logic sat);
        logic [63:0] s;
        s = tr + 64'h10000;
        if (s > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            s   = 64'hFFFF_FFFF;
        end
        return s;
    endfunction

    function automatic logic signed [31:0] add_weight(logic signed [31:0] w, longint delta,
                                                       inout logic sat);
        longint acc;
        acc = longint'(w) + delta;
        if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            sat = 1'b1;
        end
        if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            sat = 1'b1;
        end
        return acc[31:0];
    endfunction

    task automatic predict_event(logic [31:0] t, logic pre, logic post, logic restart);
        t_weight_result r;
        logic           sat;
        logic [63:0]    dt;
        sat = 1'b0;
        if (restart) begin
            pre_tr  = 0;
            post_tr = 0;
            last_t  = 0;
            wsum    = 0;
        end
        if (t < last_t) begin
            r.weight    = wsum;
            r.order_err = 1'b1;
            r.sat       = 1'b0;
        end else begin
            dt      = 64'(t - last_t);
            last_t  = t;
            pre_tr  = (pre_tr * decay_gain(dt, tau_pot) + (64'd1 << 29)) >> 30;
            post_tr = (post_tr * decay_gain(dt, tau_dep) + (64'd1 << 29)) >> 30;
            if (pre)  pre_tr  = add_spike(pre_tr, sat);
            if (post) post_tr = add_spike(post_tr, sat);
            if (t >= start_at) begin
                // depression lands first when both fire
                if (pre)
                    wsum = add_weight(wsum, -longint'((64'(amp_dep) * post_tr + 128) >> 8), sat);
                if (post)
                    wsum = add_weight(wsum, longint'((64'(amp_pot) * pre_tr + 128) >> 8), sat);
            end
            r.weight    = wsum;
            r.order_err = 1'b0;
            r.sat       = sat;
        end
        weight_q.insert(weight_q.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_weight_result want;
        if (!i_rst_n) begin
            amp_pot  = 16'd328;
            amp_dep  = 16'd344;
            tau_pot  = 20'd20000;
            tau_dep  = 20'd20000;
            start_at = 0;
            pre_tr   = 0;
            post_tr  = 0;
            last_t   = 0;
            wsum     = 0;
            weight_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AMP_POT: amp_pot  = i_cfg_data[15:0];
                    CFG_AMP_DEP: amp_dep  = i_cfg_data[15:0];
                    CFG_TAU_POT: tau_pot  = i_cfg_data[19:0];
                    CFG_TAU_DEP: tau_dep  = i_cfg_data[19:0];
                    CFG_START:   start_at = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before predicting: a result never leaves on its own input transfer
            if (i_m_tvalid && i_m_tready) begin
                if (weight_q.size() == 0) begin
                    $display("%0t: unexpected result weight %h flags %b", $time,
                             i_m_tdata, i_m_tuser);
                    o_errors++;
                end else begin
                    want = weight_q.pop_front();
                    if (i_m_tdata !== want.weight) begin
                        $display("%0t: weight_change expected %h actual %h", $time,
                                 want.weight, i_m_tdata);
                        o_errors++;
                    end
                    if (i_m_tuser[0] !== want.order_err) begin
                        $display("%0t: order_error expected %b actual %b", $time,
                                 want.order_err, i_m_tuser[0]);
                        o_errors++;
                    end
                    if (i_m_tuser[1] !== want.sat) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.sat, i_m_tuser[1]);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_event(i_s_tdata, i_s_tuser[0], i_s_tuser[1], i_s_tuser[2]);
        end
        o_pending = weight_q.size();
    end

endmodule

FILE: tb/tb_stdp_pair_weight_update.sv
// Testbench top for stdp_pair_weight_update: drives spike events, config phases and
// receiver back-pressure; stdp_checker predicts and compares the results.
// Depends on stdp_pkg, stdp_pair_weight_update and stdp_checker.
`timescale 1ns / 1ps

module tb_stdp_pair_weight_update;
    import stdp_pkg::*;

    localparam int IDLE_LIMIT  = 3000;  // cycles without any transfer
    localparam int DRAIN_WAIT  = 120;   // margin beyond the event latency
    localparam int HOLD_CYCLES = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [TIME_W-1:0]    i_s_tdata;    // [31:0] spike_time
    logic [2:0]           i_s_tuser;    // [0] pre [1] post [2] restart
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [WEIGHT_W-1:0]  o_m_tdata;    // [31:0] weight_change
    logic [1:0]           o_m_tuser;    // [0] order_error [1] saturated
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    int          err_count;
    int          pending;
    int          idle_cnt;
    bit          hold_req;     // receiver: one long hold-off
    bit          calm;         // no gaps on either side
    logic [31:0] cur_time;     // last in-order timestamp sent
    logic [19:0] tau_now;      // used to scale random time steps

    stdp_pair_weight_update u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    stdp_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (err_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("tb_stdp_pair_weight_update: errors");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // receiver: random gap per result, one long hold-off on request
    initial begin
        int gap;
        bit held;
        held       = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end
            gap = calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // one event transfer; valid drops after it unless the next call raises it at once
    task automatic send_evt(logic [31:0] t, logic pre, logic post, logic restart);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        repeat (gap) @(negedge i_clk);
        i_s_tdata  = t;
        i_s_tuser  = {restart, post, pre};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        if (restart || t >= cur_time) cur_time = t;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // registers only change with nothing in flight
    task automatic set_phase(logic [15:0] ap, logic [15:0] ad, logic [19:0] tp,
                             logic [19:0] td, logic [31:0] st);
        wait_drained();
        cfg_write(CFG_AMP_POT, {$urandom} << 16 | ap);   // upper bits are ignored
        cfg_write(CFG_AMP_DEP, 32'(ad));
        cfg_write(CFG_TAU_POT, 32'(tp));
        cfg_write(CFG_TAU_DEP, 32'(td));
        cfg_write(CFG_START, st);
        tau_now = (tp > td) ? tp : td;
        if (tau_now == 0) tau_now = 20'd1;
    endtask

    // mostly in-order streams; some restarts, out-of-order and huge jumps
    task automatic rand_event();
        int          pick;
        logic [63:0] nxt;
        logic        pre, post;
        pick = $urandom_range(0, 99);
        pre  = 1'($urandom_range(0, 1));
        post = 1'($urandom_range(0, 1));
        if (pick < 5) begin
            send_evt($urandom, pre, post, 1'b1);
        end else if (pick < 11 && cur_time != 0) begin
            send_evt(cur_time - $urandom_range(1, cur_time), pre, post, 1'b0);
        end else begin
            if (pick < 16)
                nxt = 64'(cur_time) + $urandom;
            else if (pick < 30)
                nxt = 64'(cur_time) + 64'($urandom_range(0, 40)) * tau_now;
            else
                nxt = 64'(cur_time) + $urandom_range(0, 2 * tau_now);
            if (nxt > 64'hFFFF_FFFF)
                send_evt($urandom_range(0, 1000), pre, post, 1'b1);
            else
                send_evt(nxt[31:0], pre, post, 1'b0);
        end
    endtask

    task automatic rand_block(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            rand_event();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        calm        = 1'b0;
        cur_time    = 0;
        tau_now     = 20'd20000;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: lone spikes, shared event, dt zero pair, out of order
        send_evt(0, 1'b1, 1'b0, 1'b0);
        send_evt(0, 1'b0, 1'b1, 1'b0);
        send_evt(0, 1'b1, 1'b1, 1'b0);
        send_evt(100, 1'b0, 1'b1, 1'b0);
        send_evt(100, 1'b1, 1'b0, 1'b0);
        send_evt(50, 1'b1, 1'b1, 1'b0);
        send_evt(100000, 1'b0, 1'b0, 1'b0);
        send_evt(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        send_evt(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        // restart keeps an earlier timestamp from being out of order
        send_evt(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1);
        send_evt(0, 1'b0, 1'b0, 1'b1);

        // largest amplitudes and time constants: drive the weight into both rails
        set_phase(16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 0);
        for (int i = 0; i < 8; i++) send_evt(10, 1'b1, 1'b0, 1'b0);
        for (int i = 0; i < 20; i++) send_evt(10, 1'b0, 1'b1, 1'b0);
        send_evt(20, 1'b0, 1'b1, 1'b1);
        for (int i = 0; i < 7; i++) send_evt(20, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 20; i++) send_evt(20, 1'b1, 1'b0, 1'b0);
        rand_block(80);

        // zero amplitudes, tau one, start at the last tick
        set_phase(16'd0, 16'd0, 20'd1, 20'd1, 32'hFFFF_FFFF);
        send_evt(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        rand_block(70);

        // short time constants with a mid-range start; receiver stalls long here
        set_phase(16'($urandom), 16'($urandom), 20'($urandom_range(1, 200)),
                  20'($urandom_range(1, 200)), $urandom_range(0, 20000));
        send_evt(0, 1'b0, 1'b0, 1'b1);
        rand_block(20);
        hold_req = 1'b1;
        rand_block(70);

        // zero tau behaves as one
        set_phase(16'($urandom), 16'($urandom), 20'd0, 20'd0, 32'd0);
        rand_block(80);

        // defaults back, then fully random settings
        set_phase(16'd328, 16'd344, 20'd20000, 20'd20000, 0);
        rand_block(60);
        set_phase(16'($urandom), 16'($urandom), 20'($urandom_range(1, 20'hFFFFF)),
                  20'($urandom_range(1, 5000)), $urandom);
        rand_block(60);
        set_phase(16'($urandom), 16'($urandom), 20'($urandom_range(1, 3000)),
                  20'($urandom_range(1, 3000)), $urandom_range(0, 100000));
        rand_block(60);

        wait_drained();
        if (err_count == 0) begin
            $display("tb_stdp_pair_weight_update: clean");
        end else begin
            $display("tb_stdp_pair_weight_update: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/stdp_pkg.sv
src/stdp_div.sv
src/stdp_pair_weight_update.sv
tb/stdp_checker.sv
tb/tb_stdp_pair_weight_update.sv
